// File: sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the byte-stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_ADD   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [31:0] K_R0 = 32'h5a827999;
	localparam logic [31:0] K_R1 = 32'h6ed9eba1;
	localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_R3 = 32'hca62c1d6;

	localparam logic [31:0] H_INIT0 = 32'h67452301;
	localparam logic [31:0] H_INIT1 = 32'hefcdab89;
	localparam logic [31:0] H_INIT2 = 32'h98badcfe;
	localparam logic [31:0] H_INIT3 = 32'h10325476;
	localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] LAST_OFFSET = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

// File: sv/sha1_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 hasher taking one message byte per transfer and returning the
// five digest words on a finish command.
// ----------------------------------------------------------------------------
//  channel  | signals                | payload
//  ---------+------------------------+-----------------------------------
//  msg      | msg_valid, msg_stall   | msg  : cmd, data_byte
//  dig      | dig_valid, dig_stall   | dig  : digest_word, word_index,
//           |                        |        last_word
//
//  The 64th byte of a block starts 80 rounds of the shared round unit,
//  then one chaining add. Finish pads one byte a cycle, pausing while a
//  block's rounds run (9 to 72 bytes, one or two blocks), then
//  offers five digest words, one per transfer on dig.
//  msg_stall is high whenever the hasher is busy or offering digest words.
//  After reset, and after the last digest word, the initial hash is loaded.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_core
	import sha1_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_stall,
	output dig_t dig
);

	state_t        state_q;
	logic [31:0]   h_q [5];
	logic [511:0]  blk_q;
	logic [5:0]    offset_q;
	logic [31:0]   total_q;
	logic [6:0]    rnd_q;
	logic [2:0]    widx_q;
	logic          pad_q;
	logic          first_q;
	logic          len_ok_q;
	logic          fin_q;
	logic [31:0]   a_q, b_q, c_q, d_q, e_q;

	logic          msg_xfer;
	logic          dig_xfer;
	logic          put_en;
	logic [7:0]    put_byte;
	logic          len_phase;
	logic [63:0]   bit_len;
	logic [31:0]   f_val;
	logic [31:0]   k_val;
	logic [31:0]   t_val;
	logic [31:0]   w_new;
	logic [31:0]   w_mix;

	assign msg_stall = (state_q != ST_IDLE);
	assign msg_xfer  = msg_valid && !msg_stall;
	assign dig_valid = (state_q == ST_EMIT);
	assign dig_xfer  = dig_valid && !dig_stall;

	assign dig.digest_word = h_q[widx_q];
	assign dig.word_index  = widx_q;
	assign dig.last_word   = (widx_q == LAST_WORD_IDX);

	assign bit_len   = {29'd0, total_q, 3'd0};
	assign len_phase = !first_q && len_ok_q && (offset_q >= LEN_OFFSET);

	always_comb begin
		put_en   = 1'b0;
		put_byte = msg.data_byte;
		if (state_q == ST_IDLE) begin
			put_en = msg_xfer && (msg.cmd == CMD_ABSORB);
		end else if (state_q == ST_PAD) begin
			put_en = 1'b1;
			if (first_q) begin
				put_byte = PAD_MARK;
			end else if (len_phase) begin
				put_byte = bit_len[8'd63 - {offset_q[2:0], 3'd0} -: 8];
			end else begin
				put_byte = 8'd0;
			end
		end
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = d_q ^ (b_q & (c_q ^ d_q));
			k_val = K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (d_q & (b_q | c_q));
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = f_val + k_val + {a_q[26:0], a_q[31:27]} + e_q + blk_q[511:480];
	assign w_mix = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (put_en) begin
			blk_q <= {blk_q[503:0], put_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (put_en && (offset_q == LAST_OFFSET)) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			h_q[0]   <= H_INIT0;
			h_q[1]   <= H_INIT1;
			h_q[2]   <= H_INIT2;
			h_q[3]   <= H_INIT3;
			h_q[4]   <= H_INIT4;
			offset_q <= '0;
			total_q  <= '0;
			rnd_q    <= '0;
			widx_q   <= '0;
			pad_q    <= 1'b0;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			if (put_en) begin
				offset_q <= offset_q + 6'd1;
				if (offset_q == LAST_OFFSET) begin
					state_q <= ST_ROUND;
					rnd_q   <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_xfer) begin
						if (msg.cmd == CMD_FINISH) begin
							state_q  <= ST_PAD;
							pad_q    <= 1'b1;
							first_q  <= 1'b1;
							len_ok_q <= 1'b0;
							fin_q    <= 1'b0;
						end else begin
							total_q <= total_q + 32'd1;
						end
					end
				end
				ST_PAD: begin
					if (first_q) begin
						first_q  <= 1'b0;
						len_ok_q <= (offset_q < LEN_OFFSET);
					end else if (len_phase) begin
						if (offset_q == LAST_OFFSET) begin
							fin_q <= 1'b1;
						end
					end else if (offset_q < LEN_OFFSET) begin
						len_ok_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					widx_q <= '0;
					if (fin_q) begin
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (dig_xfer) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == LAST_WORD_IDX) begin
							state_q  <= ST_IDLE;
							h_q[0]   <= H_INIT0;
							h_q[1]   <= H_INIT1;
							h_q[2]   <= H_INIT2;
							h_q[3]   <= H_INIT3;
							h_q[4]   <= H_INIT4;
							offset_q <= '0;
							total_q  <= '0;
							pad_q    <= 1'b0;
							fin_q    <= 1'b0;
							len_ok_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
